// File: rtl/suffix_automaton_builder_assert.svh
// Assertion macros for the suffix automaton builder.
// Used by the top level only; expects aclk and aresetn in scope.
`ifndef SUFFIX_AUTOMATON_BUILDER_ASSERT_SVH
`define SUFFIX_AUTOMATON_BUILDER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SAB_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SAB_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/sab_pkg.sv
// Shared codes and field widths for the suffix automaton builder.
// No dependencies.
`default_nettype none

package sab_pkg;

    // Operation codes carried on the input channel.
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_EXTEND = 2'd1;
    localparam logic [1:0] OP_MATCH  = 2'd2;

    // Result status codes.
    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_REFUSED = 1'b1;

    // Fixed field widths of the result item.
    localparam int NODE_W  = 11;
    localparam int TOTAL_W = 20;
    localparam int TEXT_W  = 11;

endpackage

`default_nettype wire

// File: rtl/sab_ram.sv
// Simple dual-port memory: one write port, one read port, registered read.
// Standalone; used by the suffix automaton builder top level.
`default_nettype none

module sab_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 11
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/suffix_automaton_builder.sv
// Clear sweeps the transition rows of nodes 0 to node_count; match does one transition read;
// refused, ignored or out-of-alphabet items go straight to the result; extend walks the
// suffix links, stops at an existing edge, and on a clone copies its edges and redirects.
// One item is in work at a time; the result register lets the next item enter while a
// result waits. After reset the transition memory is swept before s_tready rises.
`default_nettype none

module suffix_automaton_builder
    import sab_pkg::*;
#(
    parameter int MAX_TEXT      = 1024,
    parameter int ALPHABET_SIZE = 26
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // letter[4:0], pattern_start[5], zero fill
    input  wire logic [1:0]  s_tuser,   // operation[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // node_index[10:0], distinct_substrings[30:11],
                                        // text_length[41:31], zero fill
    output logic [0:0]       m_tuser    // status[0]
);

    localparam int NODES = 2 * MAX_TEXT;
    localparam int NW    = $clog2(NODES);
    localparam int LW    = $clog2(MAX_TEXT + 1);
    localparam int TD    = NODES * ALPHABET_SIZE;
    localparam int AW    = $clog2(TD);
    localparam int PW    = AW + 1;
    localparam int YW    = (ALPHABET_SIZE > 2) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int SW    = $clog2(ALPHABET_SIZE + 1);
    localparam logic [NW-1:0] ROOT = NW'(1);

    typedef enum logic [4:0] {
        ST_SWEEP, ST_IDLE, ST_CLR0, ST_CLR, ST_X1, ST_WRD, ST_WCHK,
        ST_Q1, ST_Q2, ST_Q3, ST_C1, ST_CRD, ST_CWR, ST_RRD, ST_RCHK,
        ST_L1, ST_L2, ST_FIN, ST_M1, ST_M2, ST_OUT
    } state_t;

    state_t state_reg;

    logic [YW-1:0]      sym_reg;
    logic [NW-1:0]      p_reg, q_reg, fresh_reg, nc_reg, last_reg, cur_reg, res_node_reg;
    logic [LW-1:0]      lenp_reg, lenf_reg, lenl_reg, app_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [AW-1:0]      ea_reg, src_reg, dst_reg;
    logic [SW-1:0]      cnt_reg;
    logic [PW-1:0]      lim_reg;
    logic               res_status_reg;
    logic               m_tvalid_reg;
    logic [47:0]        m_tdata_reg;

    // Input fields.
    logic [1:0] in_op;
    logic [4:0] in_letter;
    logic       in_start;
    logic       letter_ok;
    logic       accept;
    logic       refuse;

    assign in_op     = s_tuser;
    assign in_letter = s_tdata[4:0];
    assign in_start  = s_tdata[5];
    assign letter_ok = 9'(in_letter) < 9'(ALPHABET_SIZE);
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign refuse    = (app_reg >= LW'(MAX_TEXT))
                    || ((NW+1)'(nc_reg) + (NW+1)'(2) >= (NW+1)'(NODES));

    // Memory ports.
    logic          tt_we, len_we, link_we;
    logic [AW-1:0] tt_waddr, tt_raddr;
    logic [NW-1:0] tt_wdata, tt_rd;
    logic [NW-1:0] len_waddr, len_raddr, link_waddr, link_raddr;
    logic [LW-1:0] len_wdata, len_rd;
    logic [NW-1:0] link_wdata, link_rd;

    // Shared address unit: node * ALPHABET_SIZE + letter.
    logic [NW:0]   mul_node;
    logic [YW-1:0] mul_sym;
    logic [PW-1:0] prod;
    logic [NW-1:0] twin;
    logic [LW-1:0] lenp_inc;

    assign twin     = fresh_reg + NW'(1);
    assign lenp_inc = lenp_reg + LW'(1);
    assign prod     = PW'(mul_node) * PW'(ALPHABET_SIZE) + PW'(mul_sym);

    always_comb begin
        mul_node = (NW+1)'(last_reg);
        mul_sym  = sym_reg;
        unique case (state_reg)
            ST_IDLE: begin
                mul_sym = YW'(in_letter);
                if (in_op == OP_MATCH) begin
                    mul_node = in_start ? (NW+1)'(ROOT) : (NW+1)'(cur_reg);
                end
            end
            ST_WCHK, ST_RCHK: mul_node = (NW+1)'(link_rd);
            ST_Q3: begin
                mul_node = (NW+1)'(q_reg);
                mul_sym  = '0;
            end
            ST_C1: begin
                mul_node = (NW+1)'(twin);
                mul_sym  = '0;
            end
            ST_CWR: mul_node = (NW+1)'(p_reg);
            ST_CLR0: begin
                mul_node = (NW+1)'(nc_reg) + (NW+1)'(1);
                mul_sym  = '0;
            end
            default: ;
        endcase
    end

    // Memory port control per sequencer step.
    always_comb begin
        tt_we      = 1'b0;
        tt_waddr   = ea_reg;
        tt_wdata   = '0;
        tt_raddr   = ea_reg;
        len_we     = 1'b0;
        len_waddr  = ROOT;
        len_wdata  = '0;
        len_raddr  = last_reg;
        link_we    = 1'b0;
        link_waddr = ROOT;
        link_wdata = '0;
        link_raddr = p_reg;
        unique case (state_reg)
            ST_SWEEP, ST_CLR0: begin
                len_we  = 1'b1;
                link_we = 1'b1;
                tt_we   = (state_reg == ST_SWEEP);
            end
            ST_CLR: tt_we = 1'b1;
            ST_X1: begin
                len_we    = 1'b1;
                len_waddr = fresh_reg;
                len_wdata = len_rd + LW'(1);
            end
            ST_WCHK: begin
                if (tt_rd == '0) begin
                    tt_we    = 1'b1;
                    tt_wdata = fresh_reg;
                    if (link_rd == '0) begin
                        link_we    = 1'b1;
                        link_waddr = fresh_reg;
                        link_wdata = ROOT;
                    end
                end
            end
            ST_Q1: len_raddr = p_reg;
            ST_Q2: len_raddr = q_reg;
            ST_Q3: begin
                link_raddr = q_reg;
                if (lenp_inc == len_rd) begin
                    link_we    = 1'b1;
                    link_waddr = fresh_reg;
                    link_wdata = q_reg;
                end else begin
                    len_we    = 1'b1;
                    len_waddr = twin;
                    len_wdata = lenp_inc;
                end
            end
            ST_C1: begin
                link_we    = 1'b1;
                link_waddr = twin;
                link_wdata = link_rd;
            end
            ST_CRD: tt_raddr = src_reg;
            ST_CWR: begin
                tt_we    = 1'b1;
                tt_waddr = dst_reg;
                tt_wdata = tt_rd;
            end
            ST_RCHK: begin
                if (tt_rd == q_reg) begin
                    tt_we    = 1'b1;
                    tt_wdata = twin;
                end
            end
            ST_L1: begin
                link_we    = 1'b1;
                link_waddr = q_reg;
                link_wdata = twin;
            end
            ST_L2: begin
                link_we    = 1'b1;
                link_waddr = fresh_reg;
                link_wdata = twin;
            end
            default: ;
        endcase
    end

    sab_ram #(.DEPTH(TD), .WIDTH(NW)) u_trans (
        .aclk  (aclk),
        .we    (tt_we),
        .waddr (tt_waddr),
        .wdata (tt_wdata),
        .raddr (tt_raddr),
        .rdata (tt_rd)
    );

    sab_ram #(.DEPTH(NODES), .WIDTH(LW)) u_len (
        .aclk  (aclk),
        .we    (len_we),
        .waddr (len_waddr),
        .wdata (len_wdata),
        .raddr (len_raddr),
        .rdata (len_rd)
    );

    sab_ram #(.DEPTH(NODES), .WIDTH(NW)) u_link (
        .aclk  (aclk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rd)
    );

    // Sequencer, automaton registers and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_SWEEP;
            ea_reg         <= '0;
            nc_reg         <= ROOT;
            last_reg       <= ROOT;
            cur_reg        <= ROOT;
            total_reg      <= '0;
            app_reg        <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            // A taken result is dropped unless the output step reloads the register.
            if (m_tready && (state_reg != ST_OUT)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_SWEEP: begin
                    ea_reg <= ea_reg + AW'(1);
                    if (ea_reg == AW'(TD - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        sym_reg        <= YW'(in_letter);
                        res_status_reg <= STATUS_DONE;
                        res_node_reg   <= last_reg;
                        ea_reg         <= AW'(prod);
                        priority if (in_op == OP_CLEAR) begin
                            state_reg <= ST_CLR0;
                        end else if (in_op == OP_EXTEND) begin
                            if (refuse) begin
                                res_status_reg <= STATUS_REFUSED;
                                state_reg      <= ST_OUT;
                            end else if (!letter_ok) begin
                                state_reg <= ST_OUT;
                            end else begin
                                fresh_reg <= nc_reg + NW'(1);
                                p_reg     <= last_reg;
                                state_reg <= ST_X1;
                            end
                        end else if (in_op == OP_MATCH) begin
                            if (!letter_ok) begin
                                cur_reg      <= '0;
                                res_node_reg <= '0;
                                state_reg    <= ST_OUT;
                            end else begin
                                state_reg <= ST_M1;
                            end
                        end else begin
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_CLR0: begin
                    lim_reg   <= prod;
                    ea_reg    <= '0;
                    nc_reg    <= ROOT;
                    last_reg  <= ROOT;
                    cur_reg   <= ROOT;
                    total_reg <= '0;
                    app_reg   <= '0;
                    state_reg <= ST_CLR;
                end
                ST_CLR: begin
                    ea_reg <= ea_reg + AW'(1);
                    if (PW'(ea_reg) + PW'(1) == lim_reg) begin
                        res_node_reg <= ROOT;
                        state_reg    <= ST_OUT;
                    end
                end
                ST_M1: state_reg <= ST_M2;
                ST_M2: begin
                    cur_reg      <= tt_rd;
                    res_node_reg <= tt_rd;
                    state_reg    <= ST_OUT;
                end
                ST_X1: begin
                    lenf_reg  <= len_rd + LW'(1);
                    state_reg <= ST_WRD;
                end
                ST_WRD: state_reg <= ST_WCHK;
                ST_WCHK: begin
                    if (tt_rd == '0) begin
                        p_reg <= link_rd;
                        if (link_rd == '0) begin
                            lenl_reg  <= '0;
                            nc_reg    <= fresh_reg;
                            state_reg <= ST_FIN;
                        end else begin
                            ea_reg    <= AW'(prod);
                            state_reg <= ST_WRD;
                        end
                    end else begin
                        q_reg     <= tt_rd;
                        state_reg <= ST_Q1;
                    end
                end
                ST_Q1: state_reg <= ST_Q2;
                ST_Q2: begin
                    lenp_reg  <= len_rd;
                    state_reg <= ST_Q3;
                end
                ST_Q3: begin
                    if (lenp_inc == len_rd) begin
                        lenl_reg  <= len_rd;
                        nc_reg    <= fresh_reg;
                        state_reg <= ST_FIN;
                    end else begin
                        lenl_reg  <= lenp_inc;
                        nc_reg    <= twin;
                        src_reg   <= AW'(prod);
                        state_reg <= ST_C1;
                    end
                end
                ST_C1: begin
                    dst_reg   <= AW'(prod);
                    cnt_reg   <= '0;
                    state_reg <= ST_CRD;
                end
                ST_CRD: state_reg <= ST_CWR;
                ST_CWR: begin
                    src_reg <= src_reg + AW'(1);
                    dst_reg <= dst_reg + AW'(1);
                    cnt_reg <= cnt_reg + SW'(1);
                    if (cnt_reg == SW'(ALPHABET_SIZE - 1)) begin
                        ea_reg    <= AW'(prod);
                        state_reg <= ST_RRD;
                    end else begin
                        state_reg <= ST_CRD;
                    end
                end
                ST_RRD: state_reg <= ST_RCHK;
                ST_RCHK: begin
                    if (tt_rd == q_reg) begin
                        p_reg <= link_rd;
                        if (link_rd == '0) begin
                            state_reg <= ST_L1;
                        end else begin
                            ea_reg    <= AW'(prod);
                            state_reg <= ST_RRD;
                        end
                    end else begin
                        state_reg <= ST_L1;
                    end
                end
                ST_L1: state_reg <= ST_L2;
                ST_L2: state_reg <= ST_FIN;
                ST_FIN: begin
                    total_reg    <= total_reg + TOTAL_W'(lenf_reg) - TOTAL_W'(lenl_reg);
                    last_reg     <= fresh_reg;
                    app_reg      <= app_reg + LW'(1);
                    res_node_reg <= fresh_reg;
                    state_reg    <= ST_OUT;
                end
                ST_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {6'b0, TEXT_W'(app_reg), total_reg,
                                         NODE_W'(res_node_reg)};
                        m_tuser      <= res_status_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`include "suffix_automaton_builder_assert.svh"

    `SAB_ASSERT_NEXT(a_busy_after_accept, accept, !s_tready, "accepted item did not make block busy")
    `SAB_ASSERT_NOW(a_node_bound, 1'b1, (NW+1)'(nc_reg) < (NW+1)'(NODES), "node count overflow")
    `SAB_ASSERT_NOW(a_text_bound, 1'b1, app_reg <= LW'(MAX_TEXT), "text length overflow")
    `SAB_ASSERT_NOW(a_walk_node, (state_reg == ST_WCHK) || (state_reg == ST_RCHK), p_reg != '0, "walk on null node")

endmodule

`default_nettype wire
